// ===== hdl/yrgb_pkg.sv =====
// Shared types, constants and constant tables of the 4:2:0 block to RGB converter.
// Depends on nothing; the top level, yrgb_lookup, yrgb_mix and yrgb_clamp import it.
package yrgb_pkg;

  localparam int FRAC_BITS     = 13;
  localparam int TERM_W        = 24;
  localparam int SHR_W         = TERM_W - FRAC_BITS;
  localparam int PIX_N         = 4;
  localparam int LUMA_OFFSET   = 16;
  localparam int CHROMA_OFFSET = 128;
  localparam int TAB_DEPTH     = 256;

  localparam longint K_Y_MILLI  = 64'sd9535988;
  localparam longint K_RV_MILLI = 64'sd13074932;
  localparam longint K_GU_MILLI = 64'sd3203572;
  localparam longint K_GV_MILLI = 64'sd6660596;
  localparam longint K_BU_MILLI = 64'sd16531956;

  typedef logic signed [TERM_W-1:0] term_t;
  typedef term_t tab_t [TAB_DEPTH];

  // Stage 1 result: table terms of one block.
  typedef struct packed {
    term_t [PIX_N-1:0] y;
    term_t             rv;
    term_t             gu;
    term_t             gv;
    term_t             bu;
  } lut_t;

  // Stage 2 result: red and blue sums, combined green chroma term.
  typedef struct packed {
    term_t [PIX_N-1:0] y;
    term_t [PIX_N-1:0] red;
    term_t [PIX_N-1:0] blue;
    term_t             guv;
  } mix_t;

  // Stage 3 result: all unclamped channel sums.
  typedef struct packed {
    term_t [PIX_N-1:0] red;
    term_t [PIX_N-1:0] green;
    term_t [PIX_N-1:0] blue;
  } sum_t;

  // Entries are truncated toward zero, as signed division does.
  function automatic tab_t gen_tab(input longint k_milli, input longint offset);
    tab_t   tab;
    longint n;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      n      = longint'(i) - offset;
      tab[i] = term_t'((k_milli * n) / 1000);
    end
    return tab;
  endfunction

  localparam tab_t Y_TAB  = gen_tab(K_Y_MILLI, longint'(LUMA_OFFSET));
  localparam tab_t RV_TAB = gen_tab(K_RV_MILLI, longint'(CHROMA_OFFSET));
  localparam tab_t GU_TAB = gen_tab(K_GU_MILLI, longint'(CHROMA_OFFSET));
  localparam tab_t GV_TAB = gen_tab(K_GV_MILLI, longint'(CHROMA_OFFSET));
  localparam tab_t BU_TAB = gen_tab(K_BU_MILLI, longint'(CHROMA_OFFSET));

  // The upper bits of a sum are its floor shift by FRAC_BITS.
  function automatic logic [7:0] clamp8(input term_t x);
    logic [SHR_W-1:0] s;
    logic [7:0]       r;
    s = x[TERM_W-1:FRAC_BITS];
    if (s[SHR_W-1]) begin
      r = 8'h00;
    end else if (|s[SHR_W-2:8]) begin
      r = 8'hFF;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/yrgb_blk_if.sv =====
// Input channel carrying one 2x2 luma block and its shared chroma pair.
// No dependencies.
interface yrgb_blk_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_top_left;
  logic [7:0] luma_top_right;
  logic [7:0] luma_bottom_left;
  logic [7:0] luma_bottom_right;
  logic [7:0] chroma_u;
  logic [7:0] chroma_v;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_u, chroma_v,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_u, chroma_v,
    output ready
  );
endinterface

// ===== hdl/yrgb_pix_if.sv =====
// Output channel carrying four pixels of three bytes each.
// No dependencies.
interface yrgb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] top_left_byte0;
  logic [7:0] top_left_byte1;
  logic [7:0] top_left_byte2;
  logic [7:0] top_right_byte0;
  logic [7:0] top_right_byte1;
  logic [7:0] top_right_byte2;
  logic [7:0] bottom_left_byte0;
  logic [7:0] bottom_left_byte1;
  logic [7:0] bottom_left_byte2;
  logic [7:0] bottom_right_byte0;
  logic [7:0] bottom_right_byte1;
  logic [7:0] bottom_right_byte2;

  modport source (
    output valid,
           top_left_byte0, top_left_byte1, top_left_byte2,
           top_right_byte0, top_right_byte1, top_right_byte2,
           bottom_left_byte0, bottom_left_byte1, bottom_left_byte2,
           bottom_right_byte0, bottom_right_byte1, bottom_right_byte2,
    input  ready
  );
  modport sink (
    input  valid,
           top_left_byte0, top_left_byte1, top_left_byte2,
           top_right_byte0, top_right_byte1, top_right_byte2,
           bottom_left_byte0, bottom_left_byte1, bottom_left_byte2,
           bottom_right_byte0, bottom_right_byte1, bottom_right_byte2,
    output ready
  );
endinterface

// ===== hdl/yrgb_cfg_if.sv =====
// Configuration write channel for the red/blue swap register.
// No dependencies.
interface yrgb_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/yuv420_block_to_rgb.sv =====
// Top level of the 4:2:0 block to RGB converter (BT.601 video range).
// Depends on yrgb_pkg, the channel interfaces, yrgb_lookup, yrgb_mix and yrgb_clamp.
//
// The block takes one 2x2 luma block with its shared U and V samples per beat
// and returns the four converted pixels as one beat, three bytes per pixel.
// It accepts a new block in every cycle while the output is not stalled, and
// passes each block through table lookup, red and blue sums, green sum, then
// clamping into the output register. Each stage holds its contents while the
// stage after it is full, so backpressure on the output stalls the pipeline
// without loss. The swap register selects whether byte 0 carries blue or red,
// and should be written only while no beat is in flight.
module yuv420_block_to_rgb
  import yrgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  yrgb_cfg_if.sink   cfg_i,
  yrgb_blk_if.sink   blk_i,
  yrgb_pix_if.source pix_o
);

  logic swap_q;
  lut_t lut;
  sum_t sum;
  logic lut_valid, lut_ready;
  logic sum_valid, sum_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      swap_q <= cfg_i.data;
    end
  end

  yrgb_lookup u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .blk_i   (blk_i),
    .lut_o   (lut),
    .valid_o (lut_valid),
    .ready_i (lut_ready)
  );

  yrgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .lut_i   (lut),
    .valid_i (lut_valid),
    .ready_o (lut_ready),
    .sum_o   (sum),
    .valid_o (sum_valid),
    .ready_i (sum_ready)
  );

  yrgb_clamp u_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sum_i   (sum),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .swap_i  (swap_q),
    .pix_o   (pix_o)
  );

endmodule

// ===== hdl/yrgb_lookup.sv =====
// Stage 1: constant table lookups of the luma and chroma terms.
// Depends on yrgb_pkg and yrgb_blk_if.
module yrgb_lookup
  import yrgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  yrgb_blk_if.sink   blk_i,
  output lut_t       lut_o,
  output logic       valid_o,
  input  logic       ready_i
);

  logic valid_q;
  lut_t lut_q, lut_d;

  assign blk_i.ready = !valid_q || ready_i;

  always_comb begin
    lut_d.y[0] = Y_TAB[blk_i.luma_top_left];
    lut_d.y[1] = Y_TAB[blk_i.luma_top_right];
    lut_d.y[2] = Y_TAB[blk_i.luma_bottom_left];
    lut_d.y[3] = Y_TAB[blk_i.luma_bottom_right];
    lut_d.rv   = RV_TAB[blk_i.chroma_v];
    lut_d.gu   = GU_TAB[blk_i.chroma_u];
    lut_d.gv   = GV_TAB[blk_i.chroma_v];
    lut_d.bu   = BU_TAB[blk_i.chroma_u];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (blk_i.ready) begin
      valid_q <= blk_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_i.valid && blk_i.ready) begin
      lut_q <= lut_d;
    end
  end

  assign lut_o   = lut_q;
  assign valid_o = valid_q;

endmodule

// ===== hdl/yrgb_mix.sv =====
// Stages 2 and 3: adds the red and blue chroma terms to each luma term, then subtracts the green term.
// Depends on yrgb_pkg.
module yrgb_mix
  import yrgb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  lut_t lut_i,
  input  logic valid_i,
  output logic ready_o,
  output sum_t sum_o,
  output logic valid_o,
  input  logic ready_i
);

  logic mix_valid_q, sum_valid_q;
  logic mix_ready, sum_ready;
  mix_t mix_q, mix_d;
  sum_t sum_q, sum_d;

  assign sum_ready = !sum_valid_q || ready_i;
  assign mix_ready = !mix_valid_q || sum_ready;
  assign ready_o   = mix_ready;

  always_comb begin
    mix_d.y   = lut_i.y;
    mix_d.guv = term_t'($signed(lut_i.gu) + $signed(lut_i.gv));
    for (int p = 0; p < PIX_N; p++) begin
      mix_d.red[p]  = term_t'($signed(lut_i.y[p]) + $signed(lut_i.rv));
      mix_d.blue[p] = term_t'($signed(lut_i.y[p]) + $signed(lut_i.bu));
    end
  end

  always_comb begin
    sum_d.red  = mix_q.red;
    sum_d.blue = mix_q.blue;
    for (int p = 0; p < PIX_N; p++) begin
      sum_d.green[p] = term_t'($signed(mix_q.y[p]) - $signed(mix_q.guv));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (mix_ready) begin
        mix_valid_q <= valid_i;
      end
      if (sum_ready) begin
        sum_valid_q <= mix_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && mix_ready) begin
      mix_q <= mix_d;
    end
    if (mix_valid_q && sum_ready) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o   = sum_q;
  assign valid_o = sum_valid_q;

endmodule

// ===== hdl/yrgb_clamp.sv =====
// Stage 4: clamps each channel to a byte and orders red and blue by mode.
// Depends on yrgb_pkg and yrgb_pix_if.
module yrgb_clamp
  import yrgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sum_t       sum_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic       swap_i,
  yrgb_pix_if.source pix_o
);

  logic                   valid_q;
  logic [PIX_N-1:0][7:0]  b0_q, b1_q, b2_q;
  logic [PIX_N-1:0][7:0]  b0_d, b1_d, b2_d;

  assign ready_o = !valid_q || pix_o.ready;

  always_comb begin
    for (int p = 0; p < PIX_N; p++) begin
      b1_d[p] = clamp8(sum_i.green[p]);
      if (swap_i) begin
        b0_d[p] = clamp8(sum_i.red[p]);
        b2_d[p] = clamp8(sum_i.blue[p]);
      end else begin
        b0_d[p] = clamp8(sum_i.blue[p]);
        b2_d[p] = clamp8(sum_i.red[p]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      b0_q <= b0_d;
      b1_q <= b1_d;
      b2_q <= b2_d;
    end
  end

  assign pix_o.valid              = valid_q;
  assign pix_o.top_left_byte0     = b0_q[0];
  assign pix_o.top_left_byte1     = b1_q[0];
  assign pix_o.top_left_byte2     = b2_q[0];
  assign pix_o.top_right_byte0    = b0_q[1];
  assign pix_o.top_right_byte1    = b1_q[1];
  assign pix_o.top_right_byte2    = b2_q[1];
  assign pix_o.bottom_left_byte0  = b0_q[2];
  assign pix_o.bottom_left_byte1  = b1_q[2];
  assign pix_o.bottom_left_byte2  = b2_q[2];
  assign pix_o.bottom_right_byte0 = b0_q[3];
  assign pix_o.bottom_right_byte1 = b1_q[3];
  assign pix_o.bottom_right_byte2 = b2_q[3];

endmodule

// ===== hdl/yrgb_checker.sv =====
// Port-level checks of the converter and the bind that attaches them.
// Depends on yuv420_block_to_rgb and its channel interfaces.
module yrgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] out_px0_i
);

  // A stalled output beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its first pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_px0_i))
    else $error("output payload changed while stalled");

  // With the output draining, an accepted block reaches a valid output beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_i)
    else $error("block did not reach the output in time");

  // With the output draining, the input never refuses a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i && $past(out_ready_i) && $past(out_ready_i, 2) && $past(out_ready_i, 3)
      |-> in_ready_i)
    else $error("input stalled although output drains");

endmodule

bind yuv420_block_to_rgb yrgb_checker u_yrgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (blk_i.valid),
  .in_ready_i  (blk_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_px0_i   ({pix_o.top_left_byte2, pix_o.top_left_byte1, pix_o.top_left_byte0})
);

// ===== verif/yrgb_scoreboard.sv =====
// Checker for the 4:2:0 block to RGB converter: watches the block, pixel and swap channels.
// It predicts every pixel beat from each accepted block beat and compares byte by byte.
// Depends on the channel interfaces yrgb_blk_if, yrgb_pix_if and yrgb_cfg_if.
module yrgb_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  yrgb_cfg_if  cfg_i,
  yrgb_blk_if  blk_i,
  yrgb_pix_if  pix_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam longint Y_GAIN_MILLI  = 64'sd9535988;
  localparam longint RV_GAIN_MILLI = 64'sd13074932;
  localparam longint GU_GAIN_MILLI = 64'sd3203572;
  localparam longint GV_GAIN_MILLI = 64'sd6660596;
  localparam longint BU_GAIN_MILLI = 64'sd16531956;
  localparam longint LUMA_BIAS     = 64'sd16;
  localparam longint CHROMA_BIAS   = 64'sd128;
  localparam int     SCALE_SHIFT   = 13;
  localparam int     PRINT_LIMIT   = 40;

  typedef logic [11:0][7:0] quad_t;

  string byte_name [12] = '{
    "top_left_byte0", "top_left_byte1", "top_left_byte2",
    "top_right_byte0", "top_right_byte1", "top_right_byte2",
    "bottom_left_byte0", "bottom_left_byte1", "bottom_left_byte2",
    "bottom_right_byte0", "bottom_right_byte1", "bottom_right_byte2"
  };

  quad_t expected_quads [$];
  logic  swap_rb;
  int    out_beats;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Table entry: gain times offset sample, truncated toward zero.
  function automatic longint scaled_term(input longint gain, input logic [7:0] sample,
                                         input longint bias);
    return (gain * (longint'(sample) - bias)) / 1000;
  endfunction

  function automatic logic [7:0] sat_byte(input longint sum);
    longint q;
    q = sum >>> SCALE_SHIFT;
    if (q < 0) begin
      return 8'd0;
    end else if (q > 255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  function automatic quad_t convert_block(input logic [3:0][7:0] luma, input logic [7:0] u,
                                          input logic [7:0] v, input logic swap);
    longint red_c;
    longint green_c;
    longint blue_c;
    longint y;
    quad_t  q;
    red_c   = scaled_term(RV_GAIN_MILLI, v, CHROMA_BIAS);
    green_c = scaled_term(GU_GAIN_MILLI, u, CHROMA_BIAS)
            + scaled_term(GV_GAIN_MILLI, v, CHROMA_BIAS);
    blue_c  = scaled_term(BU_GAIN_MILLI, u, CHROMA_BIAS);
    for (int p = 0; p < 4; p++) begin
      y = scaled_term(Y_GAIN_MILLI, luma[p], LUMA_BIAS);
      q[p*3]   = sat_byte(y + (swap ? red_c : blue_c));
      q[p*3+1] = sat_byte(y - green_c);
      q[p*3+2] = sat_byte(y + (swap ? blue_c : red_c));
    end
    return q;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count_o < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    quad_t got;
    quad_t want;
    if (!rst_ni) begin
      swap_rb = 1'b0;
      expected_quads.delete();
      out_beats = 0;
      pending_o = 0;
    end else begin
      if (blk_i.valid && blk_i.ready) begin
        expected_quads.push_back(convert_block(
          {blk_i.luma_bottom_right, blk_i.luma_bottom_left,
           blk_i.luma_top_right, blk_i.luma_top_left},
          blk_i.chroma_u, blk_i.chroma_v, swap_rb));
      end
      if (pix_i.valid && pix_i.ready) begin
        got = {pix_i.bottom_right_byte2, pix_i.bottom_right_byte1, pix_i.bottom_right_byte0,
               pix_i.bottom_left_byte2, pix_i.bottom_left_byte1, pix_i.bottom_left_byte0,
               pix_i.top_right_byte2, pix_i.top_right_byte1, pix_i.top_right_byte0,
               pix_i.top_left_byte2, pix_i.top_left_byte1, pix_i.top_left_byte0};
        if (expected_quads.size() == 0) begin
          report_mismatch($sformatf("pixel beat %0d arrived with no block pending",
                                    out_beats));
        end else begin
          want = expected_quads.pop_front();
          for (int k = 0; k < 12; k++) begin
            if (got[k] !== want[k]) begin
              report_mismatch($sformatf("pixel beat %0d %s: got %0d, expected %0d",
                                        out_beats, byte_name[k], got[k], want[k]));
            end
          end
        end
        out_beats++;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        swap_rb = cfg_i.data;
      end
      pending_o = expected_quads.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the 4:2:0 block to RGB converter testbench: clock, reset, stimulus and verdict.
// Depends on yuv420_block_to_rgb, its channel interfaces and yrgb_scoreboard.
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int IDLE_PERCENT   = 36;

  typedef struct packed {
    logic [7:0] y_tl;
    logic [7:0] y_tr;
    logic [7:0] y_bl;
    logic [7:0] y_br;
    logic [7:0] u;
    logic [7:0] v;
  } block_t;

  localparam block_t CORNER_BLOCKS [14] = '{
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128},
    '{8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128},
    '{8'd0, 8'd255, 8'd16, 8'd235, 8'd128, 8'd128},
    '{8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd0},
    '{8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255},
    '{8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255},
    '{8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0},
    '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255},
    '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0},
    '{8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA},
    '{8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55},
    '{8'd81, 8'd145, 8'd41, 8'd210, 8'd90, 8'd240}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic src_idle_on = 1'b1;
  logic sink_idle_on = 1'b1;
  logic hold_req = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;

  yrgb_cfg_if cfg_if ();
  yrgb_blk_if blk_if ();
  yrgb_pix_if pix_if ();

  yuv420_block_to_rgb dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .blk_i  (blk_if),
    .pix_o  (pix_if)
  );

  yrgb_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .blk_i        (blk_if),
    .pix_i        (pix_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Extremes come up often; the rest is uniform.
  function automatic logic [7:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return 8'd0;
    end else if (sel == 1) begin
      return 8'd255;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic block_t random_block();
    block_t b;
    b.y_tl = pick_sample();
    b.y_tr = pick_sample();
    b.y_bl = pick_sample();
    b.y_br = pick_sample();
    b.u    = pick_sample();
    b.v    = pick_sample();
    return b;
  endfunction

  task automatic send_block(input block_t b);
    while (src_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      blk_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    blk_if.valid             <= 1'b1;
    blk_if.luma_top_left     <= b.y_tl;
    blk_if.luma_top_right    <= b.y_tr;
    blk_if.luma_bottom_left  <= b.y_bl;
    blk_if.luma_bottom_right <= b.y_br;
    blk_if.chroma_u          <= b.u;
    blk_if.chroma_v          <= b.v;
    do @(posedge clk_i); while (!blk_if.ready);
  endtask

  task automatic wait_drained();
    blk_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_swap(input logic val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_random(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        hold_req = 1'b1;
      end
      send_block(random_block());
    end
  endtask

  initial begin
    pix_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pix_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      pix_if.ready <= !(sink_idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk_i) begin
    if ((blk_if.valid && blk_if.ready) || (pix_if.valid && pix_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_ni                   = 1'b0;
    cfg_if.valid             = 1'b0;
    cfg_if.data              = 1'b0;
    blk_if.valid             = 1'b0;
    blk_if.luma_top_left     = 8'd0;
    blk_if.luma_top_right    = 8'd0;
    blk_if.luma_bottom_left  = 8'd0;
    blk_if.luma_bottom_right = 8'd0;
    blk_if.chroma_u          = 8'd0;
    blk_if.chroma_v          = 8'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (CORNER_BLOCKS[i]) begin
      send_block(CORNER_BLOCKS[i]);
    end
    wait_drained();

    write_swap(1'b1);
    foreach (CORNER_BLOCKS[i]) begin
      send_block(CORNER_BLOCKS[i]);
    end
    send_random(380, 150);
    wait_drained();

    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    write_swap(1'b0);
    send_random(400, 200);
    wait_drained();

    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    write_swap(1'b1);
    send_random(400, -1);
    wait_drained();

    write_swap(1'b0);
    send_random(440, 300);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/yrgb_pkg.sv
hdl/yrgb_blk_if.sv
hdl/yrgb_pix_if.sv
hdl/yrgb_cfg_if.sv
hdl/yrgb_lookup.sv
hdl/yrgb_mix.sv
hdl/yrgb_clamp.sv
hdl/yuv420_block_to_rgb.sv
hdl/yrgb_checker.sv
verif/yrgb_scoreboard.sv
verif/tb_top.sv
